// ----- hw/rtl/xmcrc_pkg.sv -----
package xmcrc_pkg;

   // Event kinds on the request side
   localparam logic [1:0] FUNC_BYTE    = 2'd0;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
   localparam logic [1:0] FUNC_START   = 2'd2;

   // Protocol characters
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;

   // Result status codes
   localparam logic [2:0] ST_CONTINUE   = 3'd0;
   localparam logic [2:0] ST_DELIVERED  = 3'd1;
   localparam logic [2:0] ST_END        = 3'd2;
   localparam logic [2:0] ST_CANCELLED  = 3'd3;
   localparam logic [2:0] ST_RETRY_FAIL = 3'd4;

   // Configuration register indexes
   localparam int         CSR_ADDR_W      = 1;
   localparam logic [0:0] CSR_COPY_LIMIT  = 1'b0;
   localparam logic [0:0] CSR_RETRY_LIMIT = 1'b1;

   localparam logic [7:0] COPY_LIMIT_RST  = 8'd128;
   localparam logic [7:0] RETRY_LIMIT_RST = 8'd10;
   localparam logic [7:0] SEQ_RST         = 8'd1;
   localparam logic [7:0] RETRY_MAX       = 8'hFF;
   localparam logic [7:0] MAX_DELIVER     = 8'd128;
   localparam logic [8:0] SEQ_SUM_OK      = 9'h0FF;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int PACKET_BYTES_DEF = 128;

   typedef struct packed {
      logic       clear;
      logic       start;
      logic [7:0] data;
   } crc_cmd_type;

   typedef struct packed {
      logic        busy;
      logic [15:0] crc;
   } crc_stat_type;

endpackage

// ----- hw/rtl/xmcrc_ram.sv -----
module xmcrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/xmcrc_crc_unit.sv -----
// Bit-serial CRC-16 (poly 0x1021): one data bit per cycle.
module xmcrc_crc_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  xmcrc_pkg::crc_cmd_type cmd,
   output xmcrc_pkg::crc_stat_type stat
);

   logic [15:0] crc_ff,  crc_in;
   logic [7:0]  data_ff, data_in;
   logic [2:0]  cnt_ff,  cnt_in;
   logic        busy_ff, busy_in;
   logic        fb;

   always_comb begin
      crc_in  = crc_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fb      = crc_ff[15] ^ data_ff[7];
      if (cmd.clear) begin
         crc_in = '0;
      end else if (cmd.start) begin
         data_in = cmd.data;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one message bit in, MSB first
         crc_in  = {crc_ff[14:0], 1'b0} ^ (fb ? xmcrc_pkg::CRC_POLY : 16'h0000);
         data_in = {data_ff[6:0], 1'b0};
         cnt_in  = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         crc_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         busy_ff <= busy_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.crc  = crc_ff;

endmodule

// ----- hw/rtl/xmodem_crc_receiver.sv -----
// A reply event (start, timeout, CAN, EOT, NAK, duplicate ACK) is held in S_REPLY until the
// output register is free, then loaded into it; the block is then idle and ready again.
// A packet data byte occupies the bit-serial CRC unit; ready stays low until it is done.
// A good new packet streams its data out of the packet RAM: each byte is read (S_DLV_READ)
// and packed (S_DLV_PACK), and each word of up to 8 bytes leaves from S_DLV_OUT when free.
// Reset is synchronous: it clears control state; packet RAM contents stay undefined.
module xmodem_crc_receiver #(
   parameter int PACKET_BYTES = xmcrc_pkg::PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic [1:0]  req_tuser,    // [1:0] func
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,    // [7:0] send_byte, [71:8] chunk_word,
                                     // [75:72] chunk_bytes, [78:76] status, [79] zero
   output logic [1:0]  rsp_tuser,    // [0] send_valid, [1] chunk_valid
   output logic        rsp_tlast,    // last
   // configuration writes
   input  logic                             csr_we,
   input  logic [xmcrc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]                       csr_wdata
);

   localparam int ADDR_W = $clog2(PACKET_BYTES);
   localparam int BC_W   = $clog2(PACKET_BYTES + 4);
   localparam logic [BC_W-1:0] BC_ZERO     = BC_W'(0);
   localparam logic [BC_W-1:0] BC_ONE      = BC_W'(1);
   localparam logic [BC_W-1:0] BC_TWO      = BC_W'(2);
   localparam logic [BC_W-1:0] BC_CRC_HI   = BC_W'(PACKET_BYTES + 2);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REPLY,
      S_DLV_READ,
      S_DLV_PACK,
      S_DLV_OUT
   } state_type;

   state_type state_ff, state_in;

   // protocol state
   logic            phase_ff,      phase_in;
   logic [BC_W-1:0] bc_ff,         bc_in;
   logic [7:0]      seq_ff,        seq_in;
   logic [7:0]      last_acked_ff, last_acked_in;
   logic [7:0]      retry_ff,      retry_in;
   logic [7:0]      rcv_hi_ff,     rcv_hi_in;
   logic [7:0]      copy_limit_ff, copy_limit_in;
   logic [7:0]      retry_lim_ff,  retry_lim_in;

   // pending single reply
   logic [7:0] rep_byte_ff,   rep_byte_in;
   logic [2:0] rep_status_ff, rep_status_in;

   // delivery sequencer
   logic [7:0]  dlv_idx_ff,   dlv_idx_in;
   logic [7:0]  dlv_count_ff, dlv_count_in;
   logic [3:0]  lane_ff,      lane_in;
   logic [63:0] word_ff,      word_in;
   logic        first_ff,     first_in;

   // output register
   logic        rsp_valid_ff,  rsp_valid_in;
   logic        rsp_sv_ff,     rsp_sv_in;
   logic [7:0]  rsp_sb_ff,     rsp_sb_in;
   logic        rsp_cv_ff,     rsp_cv_in;
   logic [63:0] rsp_cw_ff,     rsp_cw_in;
   logic [3:0]  rsp_cb_ff,     rsp_cb_in;
   logic [2:0]  rsp_st_ff,     rsp_st_in;
   logic        rsp_last_ff,   rsp_last_in;

   xmcrc_pkg::crc_cmd_type  crc_cmd;
   xmcrc_pkg::crc_stat_type crc_stat;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_q;

   logic        accept;
   logic        out_free;
   logic [7:0]  rx_b;
   logic [7:0]  retry_inc;
   logic [8:0]  seq_sum;
   logic [15:0] rcv_full;
   logic [7:0]  dlv_n;
   logic        dlv_done;

   xmcrc_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .cmd   (crc_cmd),
      .stat  (crc_stat)
   );

   xmcrc_ram #(
      .WIDTH (8),
      .DEPTH (PACKET_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (rx_b),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // Take a new event only when idle and the CRC unit has finished the previous byte.
   assign req_tready = (state_ff == S_IDLE) && !crc_stat.busy;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rx_b       = req_tdata;

   assign retry_inc = (retry_ff == xmcrc_pkg::RETRY_MAX) ? retry_ff : retry_ff + 8'd1;
   assign seq_sum   = {1'b0, seq_ff} + {1'b0, rx_b};
   assign rcv_full  = {rcv_hi_ff, rx_b};
   assign dlv_n     = (copy_limit_ff > xmcrc_pkg::MAX_DELIVER) ?
                      xmcrc_pkg::MAX_DELIVER : copy_limit_ff;
   assign dlv_done  = (dlv_idx_ff == dlv_count_ff);

   assign ram_waddr = ADDR_W'(bc_ff - BC_TWO);
   assign ram_raddr = ADDR_W'(dlv_idx_ff);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      bc_in         = bc_ff;
      seq_in        = seq_ff;
      last_acked_in = last_acked_ff;
      retry_in      = retry_ff;
      rcv_hi_in     = rcv_hi_ff;
      rep_byte_in   = rep_byte_ff;
      rep_status_in = rep_status_ff;
      dlv_idx_in    = dlv_idx_ff;
      dlv_count_in  = dlv_count_ff;
      lane_in       = lane_ff;
      word_in       = word_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sv_in     = rsp_sv_ff;
      rsp_sb_in     = rsp_sb_ff;
      rsp_cv_in     = rsp_cv_ff;
      rsp_cw_in     = rsp_cw_ff;
      rsp_cb_in     = rsp_cb_ff;
      rsp_st_in     = rsp_st_ff;
      rsp_last_in   = rsp_last_ff;
      crc_cmd       = '0;
      crc_cmd.data  = rx_b;
      ram_we        = 1'b0;

      copy_limit_in = (csr_we && csr_addr == xmcrc_pkg::CSR_COPY_LIMIT) ?
                      csr_wdata : copy_limit_ff;
      retry_lim_in  = (csr_we && csr_addr == xmcrc_pkg::CSR_RETRY_LIMIT) ?
                      csr_wdata : retry_lim_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  xmcrc_pkg::FUNC_START: begin
                     // fresh transfer: restore protocol state, send 'C'
                     phase_in      = 1'b0;
                     bc_in         = BC_ZERO;
                     seq_in        = xmcrc_pkg::SEQ_RST;
                     last_acked_in = 8'd0;
                     retry_in      = 8'd0;
                     rcv_hi_in     = 8'd0;
                     crc_cmd.clear = 1'b1;
                     rep_byte_in   = xmcrc_pkg::CH_C;
                     rep_status_in = xmcrc_pkg::ST_CONTINUE;
                     state_in      = S_REPLY;
                  end
                  xmcrc_pkg::FUNC_TIMEOUT: begin
                     retry_in      = retry_inc;
                     rep_byte_in   = phase_ff ? xmcrc_pkg::CH_NAK : xmcrc_pkg::CH_C;
                     rep_status_in = (retry_inc > retry_lim_ff) ?
                                     xmcrc_pkg::ST_RETRY_FAIL : xmcrc_pkg::ST_CONTINUE;
                     state_in      = S_REPLY;
                  end
                  xmcrc_pkg::FUNC_BYTE: begin
                     if (!phase_ff) begin
                        case (rx_b)
                           xmcrc_pkg::CH_CAN: begin
                              rep_byte_in   = xmcrc_pkg::CH_CAN;
                              rep_status_in = xmcrc_pkg::ST_CANCELLED;
                              state_in      = S_REPLY;
                           end
                           xmcrc_pkg::CH_SOH: begin
                              phase_in      = 1'b1;
                              bc_in         = BC_ZERO;
                              rcv_hi_in     = 8'd0;
                              retry_in      = 8'd0;
                              crc_cmd.clear = 1'b1;
                           end
                           xmcrc_pkg::CH_EOT: begin
                              rep_byte_in   = xmcrc_pkg::CH_ACK;
                              rep_status_in = xmcrc_pkg::ST_END;
                              state_in      = S_REPLY;
                           end
                           default: begin
                           end
                        endcase
                     end else if (bc_ff == BC_ZERO) begin
                        seq_in = rx_b;
                        bc_in  = BC_ONE;
                     end else if (bc_ff == BC_ONE) begin
                        // sequence plus complement must be exactly 0xFF, no wrap
                        if (seq_sum != xmcrc_pkg::SEQ_SUM_OK) begin
                           phase_in      = 1'b0;
                           bc_in         = BC_ZERO;
                           rep_byte_in   = xmcrc_pkg::CH_NAK;
                           rep_status_in = xmcrc_pkg::ST_CONTINUE;
                           state_in      = S_REPLY;
                        end else begin
                           bc_in = BC_TWO;
                        end
                     end else if (bc_ff < BC_CRC_HI) begin
                        // data byte: store it and hand it to the CRC unit
                        ram_we        = 1'b1;
                        crc_cmd.start = 1'b1;
                        bc_in         = bc_ff + BC_ONE;
                     end else if (bc_ff == BC_CRC_HI) begin
                        rcv_hi_in = rx_b;
                        bc_in     = bc_ff + BC_ONE;
                     end else begin
                        phase_in = 1'b0;
                        bc_in    = BC_ZERO;
                        if (rcv_full != crc_stat.crc) begin
                           rep_byte_in   = xmcrc_pkg::CH_NAK;
                           rep_status_in = xmcrc_pkg::ST_CONTINUE;
                           state_in      = S_REPLY;
                        end else if (seq_ff == last_acked_ff) begin
                           // duplicate: acknowledge only
                           rep_byte_in   = xmcrc_pkg::CH_ACK;
                           rep_status_in = xmcrc_pkg::ST_CONTINUE;
                           state_in      = S_REPLY;
                        end else begin
                           last_acked_in = seq_ff;
                           seq_in        = seq_ff + 8'd1;
                           if (dlv_n == 8'd0) begin
                              rep_byte_in   = xmcrc_pkg::CH_ACK;
                              rep_status_in = xmcrc_pkg::ST_DELIVERED;
                              state_in      = S_REPLY;
                           end else begin
                              dlv_count_in = dlv_n;
                              dlv_idx_in   = 8'd0;
                              lane_in      = 4'd0;
                              word_in      = '0;
                              first_in     = 1'b1;
                              state_in     = S_DLV_READ;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sv_in    = 1'b1;
               rsp_sb_in    = rep_byte_ff;
               rsp_cv_in    = 1'b0;
               rsp_cw_in    = '0;
               rsp_cb_in    = 4'd0;
               rsp_st_in    = rep_status_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_DLV_READ: begin
            // address goes to the RAM now, data returns next cycle
            dlv_idx_in = dlv_idx_ff + 8'd1;
            state_in   = S_DLV_PACK;
         end

         S_DLV_PACK: begin
            word_in = word_ff | (64'(ram_q) << {lane_ff[2:0], 3'b000});
            lane_in = lane_ff + 4'd1;
            if (lane_ff == 4'd7 || dlv_done) begin
               state_in = S_DLV_OUT;
            end else begin
               state_in = S_DLV_READ;
            end
         end

         S_DLV_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sv_in    = first_ff;
               rsp_sb_in    = first_ff ? xmcrc_pkg::CH_ACK : 8'd0;
               rsp_cv_in    = 1'b1;
               rsp_cw_in    = word_ff;
               rsp_cb_in    = lane_ff;
               rsp_st_in    = xmcrc_pkg::ST_DELIVERED;
               rsp_last_in  = dlv_done;
               first_in     = 1'b0;
               word_in      = '0;
               lane_in      = 4'd0;
               state_in     = dlv_done ? S_IDLE : S_DLV_READ;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      // payload: no reset needed
      rcv_hi_ff     <= rcv_hi_in;
      rep_byte_ff   <= rep_byte_in;
      rep_status_ff <= rep_status_in;
      dlv_idx_ff    <= dlv_idx_in;
      dlv_count_ff  <= dlv_count_in;
      lane_ff       <= lane_in;
      word_ff       <= word_in;
      first_ff      <= first_in;
      rsp_sv_ff     <= rsp_sv_in;
      rsp_sb_ff     <= rsp_sb_in;
      rsp_cv_ff     <= rsp_cv_in;
      rsp_cw_ff     <= rsp_cw_in;
      rsp_cb_ff     <= rsp_cb_in;
      rsp_st_ff     <= rsp_st_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= 1'b0;
         bc_ff         <= BC_ZERO;
         seq_ff        <= xmcrc_pkg::SEQ_RST;
         last_acked_ff <= 8'd0;
         retry_ff      <= 8'd0;
         copy_limit_ff <= xmcrc_pkg::COPY_LIMIT_RST;
         retry_lim_ff  <= xmcrc_pkg::RETRY_LIMIT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         bc_ff         <= bc_in;
         seq_ff        <= seq_in;
         last_acked_ff <= last_acked_in;
         retry_ff      <= retry_in;
         copy_limit_ff <= copy_limit_in;
         retry_lim_ff  <= retry_lim_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_st_ff, rsp_cb_ff, rsp_cw_ff, rsp_sb_ff};
   assign rsp_tuser  = {rsp_cv_ff, rsp_sv_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A data chunk always carries one to eight bytes.
   a_chunk_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[75:72] != 4'd0 && rsp_tdata[75:72] <= 4'd8)
      else $error("chunk with bad byte count");

   // Only packet delivery gives more than one result per event.
   a_multi_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[1])
      else $error("non-final result without data");

   // The CRC unit never runs while a reply or delivery is in progress.
   a_crc_idle_only: assert property (@(posedge clock) disable iff (reset)
      crc_stat.busy |-> state_ff == S_IDLE)
      else $error("CRC unit busy outside idle");

   // A reply sent together with packet data is always the ACK.
   a_data_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] && rsp_tuser[0] |-> rsp_tdata[7:0] == xmcrc_pkg::CH_ACK)
      else $error("data chunk with non-ACK reply");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

import xmcrc_pkg::*;

// One result item of the block, with the padding bit of tdata kept so it can be checked too.
typedef struct packed {
   logic        send_valid;
   logic [7:0]  send_byte;
   logic        chunk_valid;
   logic [63:0] chunk_word;
   logic [3:0]  chunk_bytes;
   logic [2:0]  status;
   logic        last;
   logic        pad;
} xm_reply_t;

// Mirror of the receiver's protocol state plus the list of replies still owed by the block.
class xmodem_reply_board;
   logic [7:0]  copy_lim;
   logic [7:0]  retry_lim;
   logic        in_pkt;
   logic [7:0]  byte_cnt;
   logic [7:0]  seq_no;
   logic [7:0]  last_ok;
   logic [7:0]  retries;
   logic [7:0]  store [PACKET_BYTES_DEF];
   logic [15:0] rx_crc;
   logic [15:0] run_crc;
   xm_reply_t   due_replies [$];
   int unsigned accepted;
   int unsigned errors;

   function new();
      copy_lim  = COPY_LIMIT_RST;
      retry_lim = RETRY_LIMIT_RST;
      accepted  = 0;
      errors    = 0;
      restart();
   endfunction

   function void restart();
      in_pkt   = 1'b0;
      byte_cnt = '0;
      seq_no   = SEQ_RST;
      last_ok  = '0;
      rx_crc   = '0;
      run_crc  = '0;
      retries  = '0;
   endfunction

   function void queue_reply(logic sv, logic [7:0] sb, logic cv, logic [63:0] cw,
                             logic [3:0] cb, logic [2:0] st, logic lst);
      xm_reply_t r;
      r = '{sv, sb, cv, cw, cb, st, lst, 1'b0};
      due_replies.push_back(r);
   endfunction

   function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Good new packet: split the delivered bytes into little-endian words
   function void deliver_packet();
      int          n;
      int          words;
      int          cnt;
      logic [63:0] word;
      n = copy_lim;
      if (n > MAX_DELIVER) n = MAX_DELIVER;
      if (n > PACKET_BYTES_DEF) n = PACKET_BYTES_DEF;
      if (n == 0) begin
         queue_reply(1'b1, CH_ACK, 1'b0, '0, '0, ST_DELIVERED, 1'b1);
         return;
      end
      words = (n + 7) / 8;
      for (int w = 0; w < words; w++) begin
         cnt = n - 8 * w;
         if (cnt > 8) cnt = 8;
         word = '0;
         for (int i = 0; i < cnt; i++)
            word[8*i +: 8] = store[8*w + i];
         queue_reply(w == 0, (w == 0) ? CH_ACK : 8'h00, 1'b1, word, 4'(cnt),
                     ST_DELIVERED, w == words - 1);
      end
   endfunction

   function void packet_byte(logic [7:0] b);
      if (byte_cnt == 0) begin
         seq_no   = b;
         byte_cnt = 1;
      end else if (byte_cnt == 1) begin
         if ({1'b0, seq_no} + {1'b0, b} != SEQ_SUM_OK) begin
            in_pkt   = 1'b0;
            byte_cnt = '0;
            queue_reply(1'b1, CH_NAK, 1'b0, '0, '0, ST_CONTINUE, 1'b1);
         end else begin
            byte_cnt = 2;
         end
      end else if (byte_cnt < PACKET_BYTES_DEF + 2) begin
         store[byte_cnt - 2] = b;
         run_crc = crc16_step(run_crc, b);
         byte_cnt++;
      end else if (byte_cnt == PACKET_BYTES_DEF + 2) begin
         rx_crc = {b, 8'h00};
         byte_cnt++;
      end else begin
         rx_crc[7:0] = b;
         in_pkt      = 1'b0;
         byte_cnt    = '0;
         if (rx_crc != run_crc) begin
            queue_reply(1'b1, CH_NAK, 1'b0, '0, '0, ST_CONTINUE, 1'b1);
         end else if (seq_no == last_ok) begin
            queue_reply(1'b1, CH_ACK, 1'b0, '0, '0, ST_CONTINUE, 1'b1);
         end else begin
            last_ok = seq_no;
            seq_no  = seq_no + 8'd1;
            deliver_packet();
         end
      end
   endfunction

   function void note_event(logic [1:0] kind, logic [7:0] b);
      accepted++;
      case (kind)
         FUNC_START: begin
            restart();
            queue_reply(1'b1, CH_C, 1'b0, '0, '0, ST_CONTINUE, 1'b1);
         end
         FUNC_TIMEOUT: begin
            if (retries != RETRY_MAX) retries++;
            queue_reply(1'b1, in_pkt ? CH_NAK : CH_C, 1'b0, '0, '0,
                        (retries > retry_lim) ? ST_RETRY_FAIL : ST_CONTINUE, 1'b1);
         end
         FUNC_BYTE: begin
            if (in_pkt) begin
               packet_byte(b);
            end else if (b == CH_CAN) begin
               queue_reply(1'b1, CH_CAN, 1'b0, '0, '0, ST_CANCELLED, 1'b1);
            end else if (b == CH_SOH) begin
               in_pkt   = 1'b1;
               byte_cnt = '0;
               run_crc  = '0;
               rx_crc   = '0;
               retries  = '0;
            end else if (b == CH_EOT) begin
               queue_reply(1'b1, CH_ACK, 1'b0, '0, '0, ST_END, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_reply(xm_reply_t got);
      xm_reply_t want;
      if (due_replies.size() == 0) begin
         $error("reply with nothing expected: send_byte %0h status %0d",
                got.send_byte, got.status);
         errors++;
         return;
      end
      want = due_replies.pop_front();
      compare_field("send_valid",  want.send_valid,  got.send_valid);
      compare_field("send_byte",   want.send_byte,   got.send_byte);
      compare_field("chunk_valid", want.chunk_valid, got.chunk_valid);
      compare_field("chunk_word",  want.chunk_word,  got.chunk_word);
      compare_field("chunk_bytes", want.chunk_bytes, got.chunk_bytes);
      compare_field("status",      want.status,      got.status);
      compare_field("last",        want.last,        got.last);
      compare_field("pad",         want.pad,         got.pad);
   endfunction
endclass

module tb_top;

   localparam int          LIMIT_CYCLES  = 400_000;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          PHASE_ITEMS   = 150;
   localparam int          PKT           = PACKET_BYTES_DEF;
   localparam logic [1:0]  FUNC_UNUSED   = 2'd3;

   typedef enum {FLAW_NONE, FLAW_DUP, FLAW_CRC, FLAW_SEQ, FLAW_TIMEOUT, FLAW_ABORT} flaw_e;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [79:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [7:0]            csr_wdata  = '0;

   xmodem_reply_board sb;

   // Sender and receiver behavior knobs, changed per phase by the main sequence
   bit          sender_gaps = 1'b1;
   int unsigned burst_left  = 0;
   int          stall_mode  = 0;
   bit          hold_req    = 1'b0;

   xmodem_crc_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one item, hold it until the block takes it, then maybe drop valid for a gap.
   // Without a gap valid stays high, so the caller must offer the next item in the same step
   // or call settle.
   task automatic send_event(input logic [1:0] kind, input logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_event(kind, b);
      if (sender_gaps) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Drop valid, wait until every owed reply has come, then let the block go quiet
   task automatic settle(input int quiet);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.due_replies.size() != 0);
      repeat (quiet) @(posedge clock);
   endtask

   // Random events, mostly header-phase traffic; a stray SOH is cleaned up by send_packet
   task automatic send_noise(input int count);
      int         pick;
      logic [7:0] b;
      repeat (count) begin
         pick = $urandom_range(0, 11);
         b    = 8'($urandom);
         case (pick)
            0, 1:    send_event(FUNC_TIMEOUT, b);
            2:       send_event(FUNC_START, b);
            3:       send_event(FUNC_UNUSED, b);
            4:       send_event(FUNC_BYTE, CH_CAN);
            5:       send_event(FUNC_BYTE, CH_EOT);
            6:       send_event(FUNC_BYTE, CH_SOH);
            default: send_event(FUNC_BYTE, b);
         endcase
      end
   endtask

   // One packet: SOH, sequence pair, 128 data bytes, CRC high then low, with an optional flaw
   task automatic send_packet(input flaw_e flaw);
      logic [7:0]  seq;
      logic [7:0]  comp;
      logic [7:0]  b;
      logic [15:0] crc;
      logic [7:0]  body [PKT];
      int          cut;
      int          fill;
      // flush a half-open packet: break its sequence pair, or run it to the end
      while (sb.in_pkt) begin
         b = (sb.byte_cnt == 1) ? (~sb.seq_no ^ 8'h3C) : 8'($urandom);
         send_event(FUNC_BYTE, b);
      end
      if (flaw == FLAW_DUP) begin
         seq = sb.last_ok;
      end else if ($urandom_range(0, 3) == 0) begin
         seq = 8'($urandom);
         if (seq == sb.last_ok) seq = seq + 8'd1;
      end else begin
         seq = sb.last_ok + 8'd1;
      end
      comp = ~seq;
      if (flaw == FLAW_SEQ) comp = comp ^ 8'($urandom_range(1, 255));
      fill = $urandom_range(0, 7);
      crc  = '0;
      for (int i = 0; i < PKT; i++) begin
         case (fill)
            0:       body[i] = 8'h00;
            1:       body[i] = 8'hFF;
            default: body[i] = 8'($urandom);
         endcase
         crc = sb.crc16_step(crc, body[i]);
      end
      if (flaw == FLAW_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
      cut = (flaw == FLAW_TIMEOUT || flaw == FLAW_ABORT) ? $urandom_range(0, PKT + 1) : -1;
      send_event(FUNC_BYTE, CH_SOH);
      send_event(FUNC_BYTE, seq);
      send_event(FUNC_BYTE, comp);
      if (flaw == FLAW_SEQ) return;
      for (int i = 0; i < PKT + 2; i++) begin
         if (i == cut) begin
            if (flaw == FLAW_ABORT) begin
               send_event(FUNC_START, 8'($urandom));
               return;
            end
            repeat ($urandom_range(1, 3)) send_event(FUNC_TIMEOUT, 8'($urandom));
         end
         if (i < PKT)
            b = body[i];
         else if (i == PKT)
            b = crc[15:8];
         else
            b = crc[7:0];
         send_event(FUNC_BYTE, b);
      end
   endtask

   // Result side: check each accepted item, then pick ready for the next cycle.
   // A hold request parks ready low until the hold count kept here runs out.
   initial begin
      int unsigned hold_left;
      int unsigned tick;
      logic        ready_next;
      xm_reply_t   got;
      hold_left = 0;
      tick      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser[0], rsp_tdata[7:0], rsp_tuser[1], rsp_tdata[71:8],
                    rsp_tdata[75:72], rsp_tdata[78:76], rsp_tlast, rsp_tdata[79]};
            sb.check_reply(got);
         end
         tick++;
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (hold_req) begin
            hold_req   = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            ready_next = 1'b0;
         end else begin
            case (stall_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = ($urandom_range(0, 3) != 0);
               default: ready_next = ((tick % 7) < 4);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Main sequence
   initial begin
      logic [9:0]  opening [19];
      logic [7:0]  copy_set [6];
      logic [7:0]  retry_set [6];
      int unsigned base;
      int          pick;
      sb = new();
      // header replies, ignored bytes, unused func, sequence pairs that fail the sum check,
      // timeout inside a packet, start in the middle of a packet
      opening = '{
         {FUNC_START, 8'h00}, {FUNC_TIMEOUT, 8'hFF}, {FUNC_BYTE, CH_CAN},
         {FUNC_BYTE, CH_EOT}, {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'hFF},
         {FUNC_UNUSED, 8'hFF}, {FUNC_UNUSED, 8'h00},
         {FUNC_BYTE, CH_SOH}, {FUNC_BYTE, 8'h80}, {FUNC_BYTE, 8'h80},
         {FUNC_BYTE, CH_SOH}, {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF},
         {FUNC_BYTE, CH_SOH}, {FUNC_BYTE, 8'h00}, {FUNC_TIMEOUT, 8'h00},
         {FUNC_BYTE, 8'hFF}, {FUNC_START, 8'hFF}
      };
      // nothing delivered, partial words, one exact word, over-limit, full packet, random
      copy_set  = '{8'd0, 8'd9, 8'd8, 8'd255, 8'd128, 8'($urandom_range(1, 127))};
      retry_set = '{8'd0, 8'd254, 8'd3, RETRY_LIMIT_RST,
                    8'($urandom_range(1, 253)), 8'($urandom_range(0, 254))};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_event(opening[i][9:8], opening[i][7:0]);

      for (int p = 0; p < 6; p++) begin
         // block must be idle before touching the registers
         settle(SETTLE_CYCLES);
         csr_we    <= 1'b1;
         csr_addr  <= CSR_COPY_LIMIT;
         csr_wdata <= copy_set[p];
         @(posedge clock);
         csr_addr  <= CSR_RETRY_LIMIT;
         csr_wdata <= retry_set[p];
         @(posedge clock);
         csr_we    <= 1'b0;
         sb.copy_lim  = copy_set[p];
         sb.retry_lim = retry_set[p];

         stall_mode  = p % 3;
         sender_gaps = (p != 4);
         base        = sb.accepted;

         // every setting sees at least one delivery
         send_packet(FLAW_NONE);
         case (p)
            1: begin
               // run the retry count past the top limit into saturation, back to back
               sender_gaps = 1'b0;
               repeat (257) send_event(FUNC_TIMEOUT, 8'($urandom));
               sender_gaps = 1'b1;
            end
            2: begin
               // park the result side while items keep coming, so the block backs up
               hold_req = 1'b1;
               send_packet(FLAW_NONE);
               send_noise(10);
            end
            3: begin
               send_packet(FLAW_DUP);
               settle(0);
            end
            default: ;
         endcase

         while (sb.accepted - base < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1, 2: send_packet(FLAW_NONE);
               3:       send_packet(FLAW_DUP);
               4:       send_packet(FLAW_CRC);
               5:       send_packet(FLAW_SEQ);
               6:       send_packet(FLAW_TIMEOUT);
               7:       send_packet(FLAW_ABORT);
               default: send_noise($urandom_range(3, 12));
            endcase
         end
      end

      // drain, then leave time for any stray extra result to show up
      settle(40);
      if (sb.errors == 0 && sb.due_replies.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("TEST FAILED");
      $finish;
   end

endmodule
